/* hw/rtl/zsl_pkg.sv */
// zsl_pkg: shared constants, payload types and ram write struct for the zipf sampler
// depends on nothing; imported by zsl_lcg, zsl_builder and the core
`default_nettype none

package zsl_pkg;

   localparam int MAX_ITEMS   = 4096;
   localparam int ADDR_W      = $clog2(MAX_ITEMS);
   localparam int CNT_W       = $clog2(MAX_ITEMS + 1);
   localparam int CFG_W       = 13;
   localparam int RANK_W      = 13;
   localparam int RAW_W       = 31;
   localparam int H_W         = 32;
   localparam int H_FRAC_BITS = 26;
   localparam int DVD_W       = H_FRAC_BITS + 1;
   localparam int STEP_W      = $clog2(DVD_W + 1);
   localparam int LCG_A_W     = 15;
   localparam int LCG_PROD_W  = RAW_W + LCG_A_W;
   localparam int PROD_W      = RAW_W + H_W;

   localparam logic [LCG_A_W-1:0] LCG_A     = LCG_A_W'(16807);
   localparam logic [RAW_W-1:0]   LCG_M     = RAW_W'(2147483647);
   localparam logic [CFG_W-1:0]   ITEM_RST  = CFG_W'(1024);
   localparam logic [RAW_W-1:0]   STATE_RST = RAW_W'(1);

   localparam logic MODE_SEED = 1'b0;
   localparam logic MODE_DRAW = 1'b1;

   typedef struct packed {
      logic             mode;
      logic [RAW_W-1:0] seed_value;
   } req_type;

   typedef struct packed {
      logic [RANK_W-1:0] rank;
      logic [RAW_W-1:0]  uniform_raw;
   } rsp_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [H_W-1:0]    data;
   } ram_wr_type;

endpackage

`default_nettype wire

/* hw/rtl/zsl_ram.sv */
// zsl_ram: generic simple dual-port ram, one write port, one registered read port
// depends on nothing
`default_nettype none

module zsl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hw/rtl/zsl_lcg.sv */
// zsl_lcg: minimal-standard lehmer generator, state register plus a registered-product step
// depends on zsl_pkg; product registered, then folded modulo 2^31-1
`default_nettype none

module zsl_lcg
   import zsl_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             seed_load,
   input  wire logic [RAW_W-1:0] seed_value,
   input  wire logic             step,
   output logic      [RAW_W-1:0] state_out
);

   logic [RAW_W-1:0]      state_ff;
   logic [LCG_PROD_W-1:0] prod_ff;
   logic                  pend_ff;
   logic [RAW_W:0]        fold;
   logic [RAW_W-1:0]      reduced;

   // mersenne fold: hi + lo, one conditional subtract; a value of m stays m (fixed point)
   always_comb begin
      fold = (RAW_W + 1)'(prod_ff[LCG_PROD_W-1:RAW_W]) + (RAW_W + 1)'(prod_ff[RAW_W-1:0]);
      if (fold > (RAW_W + 1)'(LCG_M)) begin
         reduced = RAW_W'(fold - (RAW_W + 1)'(LCG_M));
      end else begin
         reduced = RAW_W'(fold);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RST;
         pend_ff  <= 1'b0;
      end else begin
         pend_ff <= step;
         if (step) begin
            prod_ff <= LCG_PROD_W'(state_ff) * LCG_PROD_W'(LCG_A);
         end
         if (pend_ff) begin
            state_ff <= reduced;
         end else if (seed_load && (seed_value != '0)) begin
            state_ff <= seed_value;
         end
      end
   end

   assign state_out = state_ff;

   a_no_zero_state: assert property (@(posedge clock) disable iff (reset)
      state_ff != '0) else $error("generator state reached zero");

   a_step_updates: assert property (@(posedge clock) disable iff (reset)
      pend_ff |=> state_ff == $past(reduced)) else $error("step result not stored");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      step |-> !pend_ff) else $error("generator step overlaps previous step");

endmodule

`default_nettype wire

/* hw/rtl/zsl_builder.sv */
// zsl_builder: builds the harmonic prefix table, one restoring division per rank
// depends on zsl_pkg; drives the write port of the prefix ram through ram_wr_type
`default_nettype none

module zsl_builder
   import zsl_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [CNT_W-1:0] n_eff,
   output ram_wr_type            ram_wr,
   output logic                  done
);

   typedef enum logic [1:0] {
      B_IDLE,
      B_DIV,
      B_WRITE
   } bstate_type;

   bstate_type        state_ff;
   logic [CNT_W-1:0]  idx_ff;
   logic [H_W-1:0]    acc_ff;
   logic [DVD_W-1:0]  dvd_ff;
   logic [DVD_W-1:0]  quo_ff;
   logic [CNT_W-1:0]  rem_ff;
   logic [STEP_W-1:0] step_ff;
   logic              done_ff;
   ram_wr_type        wr_ff;

   logic [CNT_W:0]    rem_sh;
   logic              q_bit;
   logic [CNT_W:0]    rem_in;
   logic [H_W-1:0]    acc_in;
   logic [CNT_W-1:0]  idx_next;

   // round(2^26 / i): dividend is 2^26 + floor(i/2)
   function automatic logic [DVD_W-1:0] dividend_of(input logic [CNT_W-1:0] i);
      dividend_of = DVD_W'(1 << H_FRAC_BITS) + DVD_W'(i >> 1);
   endfunction

   always_comb begin
      rem_sh   = {rem_ff, dvd_ff[DVD_W-1]};
      q_bit    = rem_sh >= {1'b0, idx_ff};
      rem_in   = q_bit ? (rem_sh - {1'b0, idx_ff}) : rem_sh;
      acc_in   = acc_ff + H_W'(quo_ff);
      idx_next = idx_ff + CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= B_IDLE;
         done_ff   <= 1'b0;
         wr_ff.en  <= 1'b0;
      end else begin
         done_ff  <= (state_ff == B_WRITE) && (idx_ff == n_eff);
         wr_ff.en <= state_ff == B_WRITE;
         unique case (state_ff)
            B_IDLE: begin
               if (start) begin
                  idx_ff   <= CNT_W'(1);
                  acc_ff   <= '0;
                  dvd_ff   <= dividend_of(CNT_W'(1));
                  quo_ff   <= '0;
                  rem_ff   <= '0;
                  step_ff  <= STEP_W'(DVD_W);
                  state_ff <= B_DIV;
               end
            end
            B_DIV: begin
               rem_ff  <= CNT_W'(rem_in);
               dvd_ff  <= {dvd_ff[DVD_W-2:0], 1'b0};
               quo_ff  <= {quo_ff[DVD_W-2:0], q_bit};
               step_ff <= step_ff - STEP_W'(1);
               if (step_ff == STEP_W'(1)) begin
                  state_ff <= B_WRITE;
               end
            end
            B_WRITE: begin
               acc_ff     <= acc_in;
               wr_ff.addr <= ADDR_W'(idx_ff - CNT_W'(1));
               wr_ff.data <= acc_in;
               if (idx_ff == n_eff) begin
                  state_ff <= B_IDLE;
               end else begin
                  idx_ff   <= idx_next;
                  dvd_ff   <= dividend_of(idx_next);
                  quo_ff   <= '0;
                  rem_ff   <= '0;
                  step_ff  <= STEP_W'(DVD_W);
                  state_ff <= B_DIV;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

   assign ram_wr = wr_ff;
   assign done   = done_ff;

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      state_ff == B_DIV |-> rem_ff < idx_ff) else $error("division remainder out of range");

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff != B_IDLE |-> (idx_ff != '0) && (idx_ff <= n_eff))
      else $error("build index out of range");

   a_done_with_write: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> wr_ff.en) else $error("build finished without final write");

endmodule

`default_nettype wire

/* hw/rtl/zipf_sampler_lehmer_core.sv */
// Zipf sampler (exponent 1) on a minimal-standard lehmer generator. A seed
// transaction (mode 0) loads a nonzero seed into the generator and gives no response; a draw
// transaction (mode 1) advances the generator to x and returns the smallest rank i
// with H_i*(2^31-1) >= x*H_n, together with x. One transaction is in work at a time;
// a finished response waits in the output register and does not block the next
// request. A draw holds the request side through the binary search, which spends one
// ram read and one compare per step, and while its response waits for the output
// register. The first draw after reset or after a write of item_count first rebuilds
// the prefix table, one division and one write per rank.
// depends on zsl_pkg, zsl_ram, zsl_lcg, zsl_builder
`default_nettype none

module zipf_sampler_lehmer_core
   import zsl_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire req_type          req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output rsp_type               rsp_data,
   input  wire logic             csr_write_enable,
   input  wire logic [CFG_W-1:0] csr_write_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_BUILD,
      S_TOP_RD,
      S_RHS,
      S_SRCH_RD,
      S_SRCH_CMP,
      S_DONE
   } state_type;

   state_type         state_ff;
   logic [CFG_W-1:0]  item_count_ff;
   logic              ready_ff;
   logic              build_start_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;
   logic [PROD_W-1:0] rhs_ff;
   logic [CNT_W-1:0]  lo_ff;
   logic [CNT_W-1:0]  hi_ff;
   logic [CNT_W-1:0]  mid_ff;

   logic [CNT_W-1:0]  n_eff;
   logic              req_accept;
   logic              seed_load;
   logic              draw_step;
   logic [RAW_W-1:0]  lcg_x;
   ram_wr_type        ram_wr;
   logic              build_done;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [H_W-1:0]    rd_data;
   logic [CNT_W-1:0]  mid_calc;
   logic [PROD_W-1:0] lhs;

   always_comb begin
      priority if (item_count_ff == '0) begin
         n_eff = CNT_W'(1);
      end else if (32'(item_count_ff) > 32'(MAX_ITEMS)) begin
         n_eff = CNT_W'(MAX_ITEMS);
      end else begin
         n_eff = CNT_W'(item_count_ff);
      end
   end

   assign req_stall  = state_ff != S_IDLE;
   assign req_accept = req_valid && !req_stall;
   assign seed_load  = req_accept && (req_data.mode == MODE_SEED);
   assign draw_step  = req_accept && (req_data.mode == MODE_DRAW);

   assign mid_calc = lo_ff + ((hi_ff - lo_ff) >> 1);
   // H*(2^31-1) as a shift and subtract
   assign lhs = {rd_data, RAW_W'(0)} - PROD_W'(rd_data);

   always_comb begin
      rd_en   = 1'b0;
      rd_addr = '0;
      unique case (state_ff)
         S_TOP_RD: begin
            rd_en   = 1'b1;
            rd_addr = ADDR_W'(n_eff - CNT_W'(1));
         end
         S_SRCH_RD: begin
            rd_en   = lo_ff < hi_ff;
            rd_addr = ADDR_W'(mid_calc - CNT_W'(1));
         end
         default: begin
            rd_en   = 1'b0;
            rd_addr = '0;
         end
      endcase
   end

   zsl_lcg u_lcg (
      .clock      (clock),
      .reset      (reset),
      .seed_load  (seed_load),
      .seed_value (req_data.seed_value),
      .step       (draw_step),
      .state_out  (lcg_x)
   );

   zsl_builder u_builder (
      .clock  (clock),
      .reset  (reset),
      .start  (build_start_ff),
      .n_eff  (n_eff),
      .ram_wr (ram_wr),
      .done   (build_done)
   );

   zsl_ram #(
      .WIDTH (H_W),
      .DEPTH (MAX_ITEMS)
   ) u_prefix_ram (
      .clock   (clock),
      .wr_en   (ram_wr.en),
      .wr_addr (ram_wr.addr),
      .wr_data (ram_wr.data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         item_count_ff  <= ITEM_RST;
         ready_ff       <= 1'b0;
         build_start_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         build_start_ff <= draw_step && !ready_ff;
         // load a finished draw, else drain the output register
         if ((state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (draw_step) begin
                  if (ready_ff) begin
                     state_ff <= S_TOP_RD;
                  end else begin
                     state_ff <= S_BUILD;
                  end
               end
            end
            S_BUILD: begin
               if (build_done) begin
                  ready_ff <= 1'b1;
                  state_ff <= S_TOP_RD;
               end
            end
            S_TOP_RD: begin
               state_ff <= S_RHS;
            end
            S_RHS: begin
               rhs_ff   <= PROD_W'(lcg_x) * PROD_W'(rd_data);
               lo_ff    <= CNT_W'(1);
               hi_ff    <= n_eff;
               state_ff <= S_SRCH_RD;
            end
            S_SRCH_RD: begin
               if (lo_ff < hi_ff) begin
                  mid_ff   <= mid_calc;
                  state_ff <= S_SRCH_CMP;
               end else begin
                  state_ff <= S_DONE;
               end
            end
            S_SRCH_CMP: begin
               if (lhs >= rhs_ff) begin
                  hi_ff <= mid_ff;
               end else begin
                  lo_ff <= mid_ff + CNT_W'(1);
               end
               state_ff <= S_SRCH_RD;
            end
            S_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_data_ff.rank        <= RANK_W'(lo_ff);
                  rsp_data_ff.uniform_raw <= lcg_x;
                  state_ff                <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
         // user writes only while idle (unenforced); a new count invalidates the table
         if (csr_write_enable) begin
            item_count_ff <= csr_write_data;
            ready_ff      <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_write_only_building: assert property (@(posedge clock) disable iff (reset)
      ram_wr.en |-> state_ff == S_BUILD) else $error("prefix ram written outside build");

   a_table_before_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_TOP_RD |-> ready_ff) else $error("prefix table read before built");

   a_search_bounds: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SRCH_CMP |-> (lo_ff <= mid_ff) && (mid_ff < hi_ff))
      else $error("search midpoint out of bounds");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("response raised outside done state");

   a_rank_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff.rank != '0) else $error("response rank is zero");

endmodule

`default_nettype wire
